// ----- hw/rtl/crank_nicolson_diffusion_step_top_assert.svh -----
// assertion macros for the diffusion step block
`ifndef CRANK_NICOLSON_DIFFUSION_STEP_TOP_ASSERT_SVH
`define CRANK_NICOLSON_DIFFUSION_STEP_TOP_ASSERT_SVH

// same-cycle implication, sampled on clk, off during rst
`define CNDS_ASSERT_IMP(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("cnds check failed");

// next-cycle implication, sampled on clk, off during rst
`define CNDS_ASSERT_NXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("cnds check failed");

`endif

// ----- hw/rtl/cnds_pkg.sv -----
`default_nettype none
package cnds_pkg;

  // divider widths: dividend holds |num|<<16 plus half divisor
  localparam int DVD_W = 51;
  localparam int DVS_W = 48;
  localparam int CNT_W = 6;

  typedef struct packed {
    logic             start;
    logic [DVD_W-1:0] dividend;
    logic [DVS_W-1:0] divisor;
  } div_req_t;

  typedef struct packed {
    logic             done;
    logic             busy;
    logic [DVD_W-1:0] quotient;
  } div_rsp_t;

  // clamp to signed 32-bit range
  function automatic logic signed [31:0] sat32(input logic signed [63:0] v);
    logic signed [31:0] r;
    if (v > 64'sh7FFF_FFFF) begin
      r = 32'sh7FFF_FFFF;
    end else if (v < -64'sh8000_0000) begin
      r = 32'sh8000_0000;
    end else begin
      r = v[31:0];
    end
    return r;
  endfunction

  // apply sign to an unsigned quotient and clamp
  function automatic logic signed [31:0] sat_q(input logic [DVD_W-1:0] q, input logic neg);
    logic [DVD_W-1:0]   nq;
    logic signed [31:0] r;
    nq = '0 - q;
    if (!neg) begin
      r = (q > DVD_W'(32'h7FFF_FFFF)) ? 32'sh7FFF_FFFF : signed'(q[31:0]);
    end else begin
      r = (q > DVD_W'(32'h8000_0000)) ? 32'sh8000_0000 : signed'(nq[31:0]);
    end
    return r;
  endfunction

endpackage
`default_nettype wire

// ----- hw/rtl/cnds_ram.sv -----
`default_nettype none
module cnds_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 64
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic                     re,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // one write port, one registered read port that holds its data
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule
`default_nettype wire

// ----- hw/rtl/cnds_mul.sv -----
`default_nettype none
module cnds_mul (
  input  wire logic               clk,
  input  wire logic signed [32:0] a,
  input  wire logic signed [31:0] b,
  output logic signed      [48:0] prod
);

  logic [31:0] ma;
  logic [31:0] mb;
  logic [63:0] p;
  logic [47:0] r;
  logic        neg;

  // q16.16 product on magnitudes, round half away from zero
  always_comb begin
    ma  = a[32] ? 32'(-a) : a[31:0];
    mb  = b[31] ? 32'(-33'(b)) : b[31:0];
    p   = 64'(ma) * 64'(mb);
    r   = 48'((p + 64'h8000) >> 16);
    neg = a[32] ^ b[31];
  end

  always_ff @(posedge clk) begin
    prod <= neg ? -signed'({1'b0, r}) : signed'({1'b0, r});
  end

endmodule
`default_nettype wire

// ----- hw/rtl/cnds_div.sv -----
`default_nettype none
module cnds_div (
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire cnds_pkg::div_req_t req,
  output cnds_pkg::div_rsp_t     rsp
);

  logic [cnds_pkg::DVS_W-1:0] rem;
  logic [cnds_pkg::DVD_W-1:0] quo;
  logic [cnds_pkg::DVS_W-1:0] dv;
  logic [cnds_pkg::CNT_W-1:0] cnt;
  logic                       busy;
  logic                       done;
  logic [cnds_pkg::DVS_W:0]   shifted;
  logic [cnds_pkg::DVS_W:0]   diff;

  // one restoring step: shift in next dividend bit, try subtract
  always_comb begin
    shifted = {rem, quo[cnds_pkg::DVD_W-1]};
    diff    = shifted - {1'b0, dv};
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= !req.start && busy && (cnt == cnds_pkg::CNT_W'(1));
      if (req.start) begin
        busy <= 1'b1;
        cnt  <= cnds_pkg::CNT_W'(cnds_pkg::DVD_W);
      end else if (busy) begin
        cnt <= cnt - 1'b1;
        if (cnt == cnds_pkg::CNT_W'(1)) begin
          busy <= 1'b0;
        end
      end
    end
  end

  // datapath, one quotient bit per cycle while busy
  always_ff @(posedge clk) begin
    if (req.start) begin
      rem <= '0;
      quo <= req.dividend;
      dv  <= req.divisor;
    end else if (busy) begin
      if (!diff[cnds_pkg::DVS_W]) begin
        rem <= diff[cnds_pkg::DVS_W-1:0];
        quo <= {quo[cnds_pkg::DVD_W-2:0], 1'b1};
      end else begin
        rem <= shifted[cnds_pkg::DVS_W-1:0];
        quo <= {quo[cnds_pkg::DVD_W-2:0], 1'b0};
      end
    end
  end

  assign rsp.done     = done;
  assign rsp.busy     = busy;
  assign rsp.quotient = quo;

endmodule
`default_nettype wire

// ----- hw/rtl/crank_nicolson_diffusion_step_top.sv -----
`default_nettype none
// crank-nicolson diffusion step on a 1d grid of GRID_POINTS nodes
// s_* channel: one request per time step, tdata = boundary gradient (q16.16)
// m_* channel: one result per step, tdata = left flux, right flux, elapsed time
// cfg_*: write alpha (index 0) and time_step (index 1) while the block is idle
// each step takes a forward pass (explicit half plus elimination) and a back
// substitution pass. most of a step is spent in the shared bit-serial divider:
// two quotients for each of the first GRID_POINTS-1 grid points, plus one for
// the ghost term
// s_tready is high only between steps; one request is worked on at a time
// after rst the grid memory is swept to zero, with s_tready low; alpha,
// time_step and elapsed time reset to zero
// the result sits in an output register; if m_tready is low the next request
// is still taken, and the block holds its finished result until the register
// frees up
module crank_nicolson_diffusion_step_top #(
  parameter int GRID_POINTS = 64
) (
  input  wire logic         clk,
  input  wire logic         rst,
  input  wire logic         s_tvalid,
  output logic              s_tready,
  input  wire logic [31:0]  s_tdata,   // [31:0] boundary_gradient
  output logic              m_tvalid,
  input  wire logic         m_tready,
  output logic      [111:0] m_tdata,   // [31:0] left_flux, [63:32] right_flux,
                                       // [111:64] elapsed_time
  input  wire logic         cfg_we,
  input  wire logic         cfg_index,
  input  wire logic [31:0]  cfg_data
);

  localparam int IW = $clog2(GRID_POINTS);
  localparam logic [IW-1:0] LAST   = IW'(GRID_POINTS - 1);
  localparam logic [IW-1:0] LASTM1 = IW'(GRID_POINTS - 2);

  localparam logic CFG_ALPHA = 1'b0;
  localparam logic CFG_TSTEP = 1'b1;

  localparam logic [3:0] S_CLEAR = 4'd0;
  localparam logic [3:0] S_IDLE  = 4'd1;
  localparam logic [3:0] S_GHOST = 4'd2;
  localparam logic [3:0] S_LOAD  = 4'd3;
  localparam logic [3:0] S_LAP   = 4'd4;
  localparam logic [3:0] S_RHS   = 4'd5;
  localparam logic [3:0] S_DEN   = 4'd6;
  localparam logic [3:0] S_NUM   = 4'd7;
  localparam logic [3:0] S_DIVU  = 4'd8;
  localparam logic [3:0] S_WU    = 4'd9;
  localparam logic [3:0] S_DIVR  = 4'd10;
  localparam logic [3:0] S_WR    = 4'd11;
  localparam logic [3:0] S_BRD   = 4'd12;
  localparam logic [3:0] S_BMUL  = 4'd13;
  localparam logic [3:0] S_BWR   = 4'd14;
  localparam logic [3:0] S_OUT   = 4'd15;

  logic [3:0]         state;
  logic [31:0]        alpha;
  logic [31:0]        time_step;
  logic [47:0]        time_acc;
  logic [IW-1:0]      idx;
  logic [IW-1:0]      clr;
  logic signed [31:0] g_in;
  logic signed [32:0] ghost;
  logic signed [31:0] wm, wc, wp;
  logic signed [31:0] rhs;
  logic signed [33:0] num;
  logic [47:0]        den;
  logic signed [31:0] mu_prev, mr_prev;
  logic signed [31:0] gnext, g0, g1, grf;

  // shared arithmetic
  logic signed [32:0] mul_a;
  logic signed [31:0] mul_b;
  logic signed [48:0] mul_p;
  cnds_pkg::div_req_t div_req;
  cnds_pkg::div_rsp_t div_rsp;

  // memories
  logic          g_we, g_re;
  logic [IW-1:0] g_waddr, g_raddr;
  logic [31:0]   g_wdata, g_rdata;
  logic          s_we, s_re;
  logic [31:0]   mu_wdata, mr_wdata, mu_rdata, mr_rdata;

  // combinational helpers
  logic               first;
  logic signed [31:0] lap_d, rhs_v, num_v, mu_v, mr_v, gi_v, lf_v, rf_v;
  logic signed [63:0] den_w;
  logic [33:0]        base;
  logic [32:0]        num_u;
  logic [33:0]        num_mag;
  logic [32:0]        g2_mag;
  logic [IW:0]        nx;

  cnds_mul u_mul (.clk(clk), .a(mul_a), .b(mul_b), .prod(mul_p));
  cnds_div u_div (.clk(clk), .rst(rst), .req(div_req), .rsp(div_rsp));

  cnds_ram #(.WIDTH(32), .DEPTH(GRID_POINTS)) u_grid (
    .clk(clk), .we(g_we), .waddr(g_waddr), .wdata(g_wdata),
    .re(g_re), .raddr(g_raddr), .rdata(g_rdata)
  );
  cnds_ram #(.WIDTH(32), .DEPTH(GRID_POINTS)) u_upper (
    .clk(clk), .we(s_we), .waddr(idx), .wdata(mu_wdata),
    .re(s_re), .raddr(idx), .rdata(mu_rdata)
  );
  cnds_ram #(.WIDTH(32), .DEPTH(GRID_POINTS)) u_rhs (
    .clk(clk), .we(s_we), .waddr(idx), .wdata(mr_wdata),
    .re(s_re), .raddr(idx), .rdata(mr_rdata)
  );

  assign s_tready = (state == S_IDLE);

  // arithmetic terms of the current grid point
  always_comb begin
    first   = (idx == '0);
    base    = 34'(65536) + {1'b0, alpha, 1'b0};
    if (first) begin
      lap_d = cnds_pkg::sat32(64'(wp) - 64'(wc) - 64'(ghost));
      rhs_v = cnds_pkg::sat32(64'(wc) + 64'(mul_p) + 64'(mul_p));
      num_u = {alpha, 1'b0};
    end else begin
      lap_d = cnds_pkg::sat32(64'(wp) - 64'(wc) - 64'(wc) + 64'(wm));
      rhs_v = cnds_pkg::sat32(64'(wc) + 64'(mul_p));
      num_u = {1'b0, alpha};
    end
    den_w   = 64'(signed'({1'b0, base})) + 64'(mul_p);
    num_v   = cnds_pkg::sat32(64'(rhs) + 64'(mul_p));
    num_mag = num[33] ? 34'(-num) : num;
    // magnitude of twice the incoming gradient
    g2_mag  = (s_tdata[31] ? 33'(-33'(signed'(s_tdata))) : 33'(s_tdata)) << 1;
    mu_v    = cnds_pkg::sat_q(div_rsp.quotient, 1'b1);
    mr_v    = cnds_pkg::sat_q(div_rsp.quotient, num[33]);
    gi_v    = cnds_pkg::sat32(64'(signed'(mr_rdata)) - 64'(mul_p));
    lf_v    = cnds_pkg::sat32((64'(g0) - 64'(g1)) * 64'(GRID_POINTS));
    rf_v    = cnds_pkg::sat32(64'(grf) * 64'(GRID_POINTS));
    nx      = {1'b0, idx} + (IW+1)'(2);
  end

  // multiplier operands, result used in the following state
  always_comb begin
    mul_a = signed'({1'b0, alpha});
    mul_b = '0;
    case (state)
      S_LAP:   mul_b = lap_d;
      S_RHS:   mul_b = mu_prev;
      S_DEN:   mul_b = mr_prev;
      S_BMUL: begin
        mul_a = 33'(signed'(mu_rdata));
        mul_b = gnext;
      end
      default: mul_b = '0;
    endcase
  end

  // divider requests
  always_comb begin
    div_req.start    = 1'b0;
    div_req.dividend = '0;
    div_req.divisor  = cnds_pkg::DVS_W'(GRID_POINTS);
    case (state)
      S_IDLE: begin
        div_req.start    = s_tvalid;
        div_req.dividend = cnds_pkg::DVD_W'(g2_mag);
      end
      S_DIVU: begin
        div_req.start    = 1'b1;
        div_req.dividend = (cnds_pkg::DVD_W'(num_u) << 16) + cnds_pkg::DVD_W'(den >> 1);
        div_req.divisor  = den;
      end
      S_DIVR: begin
        div_req.start    = 1'b1;
        div_req.dividend = (cnds_pkg::DVD_W'(num_mag) << 16) + cnds_pkg::DVD_W'(den >> 1);
        div_req.divisor  = den;
      end
      default: div_req.start = 1'b0;
    endcase
  end

  // memory port control
  always_comb begin
    g_we     = 1'b0;
    g_waddr  = clr;
    g_wdata  = '0;
    g_re     = 1'b0;
    g_raddr  = '0;
    s_we     = (state == S_WR) && div_rsp.done;
    s_re     = (state == S_BRD);
    mu_wdata = mu_prev;
    mr_wdata = mr_v;
    case (state)
      S_CLEAR: g_we = 1'b1;
      S_IDLE:  g_re = s_tvalid;
      S_GHOST: begin
        g_re    = div_rsp.done;
        g_raddr = IW'(1);
      end
      S_LAP: begin
        g_re    = 1'b1;
        g_raddr = (nx > (IW+1)'(GRID_POINTS - 1)) ? LAST : nx[IW-1:0];
      end
      S_BWR: begin
        g_we    = 1'b1;
        g_waddr = idx;
        g_wdata = gi_v;
      end
      default: g_re = 1'b0;
    endcase
  end

  // configuration writes
  always_ff @(posedge clk) begin
    if (rst) begin
      alpha     <= '0;
      time_step <= '0;
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_ALPHA: alpha     <= cfg_data;
        CFG_TSTEP: time_step <= cfg_data;
        default:   alpha     <= alpha;
      endcase
    end
  end

  // sequencer
  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= S_CLEAR;
      clr      <= '0;
      m_tvalid <= 1'b0;
      time_acc <= '0;
    end else begin
      if (m_tready && state != S_OUT) begin
        m_tvalid <= 1'b0;
      end
      case (state)
        // zero the grid after reset
        S_CLEAR: begin
          if (clr == LAST) begin
            state <= S_IDLE;
          end else begin
            clr <= clr + 1'b1;
          end
        end
        S_IDLE: begin
          if (s_tvalid) begin
            g_in  <= signed'(s_tdata);
            state <= S_GHOST;
          end
        end
        // ghost flux term, old[0] arrives
        S_GHOST: begin
          if (div_rsp.done) begin
            ghost <= g_in[31] ? -signed'(div_rsp.quotient[32:0])
                              : signed'(div_rsp.quotient[32:0]);
            wc    <= signed'(g_rdata);
            wm    <= '0;
            idx   <= '0;
            state <= S_LOAD;
          end
        end
        S_LOAD: begin
          wp    <= signed'(g_rdata);
          state <= S_LAP;
        end
        S_LAP:  state <= S_RHS;
        // explicit half of the scheme
        S_RHS: begin
          if (first) begin
            num   <= 34'(rhs_v);
            den   <= 48'(base);
            state <= S_DIVU;
          end else begin
            rhs   <= rhs_v;
            state <= S_DEN;
          end
        end
        // elimination pivot, tiny pivots forced to one lsb
        S_DEN: begin
          den   <= (den_w < 64'sd1) ? 48'd1 : den_w[47:0];
          state <= S_NUM;
        end
        S_NUM: begin
          num   <= 34'(num_v);
          state <= S_DIVU;
        end
        S_DIVU: state <= S_WU;
        S_WU: begin
          if (div_rsp.done) begin
            mu_prev <= mu_v;
            state   <= S_DIVR;
          end
        end
        S_DIVR: state <= S_WR;
        // store coefficients, slide the window
        S_WR: begin
          if (div_rsp.done) begin
            mr_prev <= mr_v;
            wm      <= wc;
            wc      <= wp;
            wp      <= signed'(g_rdata);
            if (idx == LASTM1) begin
              gnext <= '0;
              state <= S_BRD;
            end else begin
              idx   <= idx + 1'b1;
              state <= S_LAP;
            end
          end
        end
        S_BRD:  state <= S_BMUL;
        S_BMUL: state <= S_BWR;
        // back substitution
        S_BWR: begin
          if (idx == LASTM1) begin
            grf <= gi_v;
          end
          gnext <= gi_v;
          if (idx == '0) begin
            g0    <= gi_v;
            g1    <= gnext;
            state <= S_OUT;
          end else begin
            idx   <= idx - 1'b1;
            state <= S_BRD;
          end
        end
        S_OUT: begin
          if (!m_tvalid || m_tready) begin
            m_tdata  <= {time_acc + 48'(time_step), rf_v, lf_v};
            time_acc <= time_acc + 48'(time_step);
            m_tvalid <= 1'b1;
            state    <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

`include "crank_nicolson_diffusion_step_top_assert.svh"

  `CNDS_ASSERT_NXT(a_accept_starts_div, s_tvalid && s_tready, state == S_GHOST && div_rsp.busy)
  `CNDS_ASSERT_IMP(a_done_when_waiting, div_rsp.done,
                   state == S_GHOST || state == S_WU || state == S_WR)
  `CNDS_ASSERT_NXT(a_result_loaded, state == S_OUT && (!m_tvalid || m_tready), m_tvalid)

endmodule
`default_nettype wire

// ----- bench/tb_crank_nicolson_diffusion_step_top.sv -----
`timescale 1ns / 1ps
module tb_crank_nicolson_diffusion_step_top;

  localparam int GRID_POINTS = 64;
  localparam int WATCHDOG_LIMIT = 120000;
  localparam int HOLD_CYCLES = 20000;
  localparam int SETTLE_CYCLES = 300;

  // register indexes of the configuration port
  localparam logic REG_ALPHA = 1'b0;
  localparam logic REG_TIME_STEP = 1'b1;

  typedef struct packed {
    logic [31:0] left_flux;
    logic [31:0] right_flux;
    logic [47:0] elapsed_time;
  } flux_result_t;

  logic          clk = 1'b0;
  logic          rst = 1'b1;
  logic          s_tvalid = 1'b0;
  logic          s_tready;
  logic [31:0]   s_tdata = '0;   // [31:0] boundary_gradient
  logic          m_tvalid;
  logic          m_tready = 1'b0;
  logic [111:0]  m_tdata;        // [31:0] left_flux, [63:32] right_flux,
                                 // [111:64] elapsed_time
  logic          cfg_we = 1'b0;
  logic          cfg_index = 1'b0;
  logic [31:0]   cfg_data = '0;

  crank_nicolson_diffusion_step_top #(.GRID_POINTS(GRID_POINTS)) dut (
    .clk(clk), .rst(rst),
    .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata),
    .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  always #4 clk = ~clk;

  // predictor state
  logic [31:0]        alpha_q;
  logic [31:0]        time_step_q;
  logic signed [31:0] heat_grid [GRID_POINTS];
  logic [47:0]        elapsed_q;
  flux_result_t       pending_fluxes [$];

  int  error_count = 0;
  int  sender_idle_pct = 0;
  int  receiver_stall_pct = 0;
  bit  hold_active = 1'b0;
  int  quiet_cycles = 0;
  event hold_ev;

  function automatic longint clamp32(input longint v);
    if (v > 64'sd2147483647) return 64'sd2147483647;
    if (v < -64'sd2147483648) return -64'sd2147483648;
    return v;
  endfunction

  // q16.16 product, halves away from zero
  function automatic longint fx_mul(input longint a, input longint b);
    longint unsigned ma, mb, r;
    ma = (a < 0) ? longint'(-a) : a;
    mb = (b < 0) ? longint'(-b) : b;
    r = (ma * mb + 64'h8000) >> 16;
    return ((a < 0) != (b < 0)) ? -longint'(r) : longint'(r);
  endfunction

  // q16.16 quotient, den > 0, halves away from zero
  function automatic longint fx_div(input longint num, input longint den);
    longint unsigned mn, d, q;
    mn = (num < 0) ? longint'(-num) : num;
    d = den;
    q = ((mn << 16) + d / 2) / d;
    return (num < 0) ? -longint'(q) : longint'(q);
  endfunction

  // one crank-nicolson step of the predictor grid
  function automatic flux_result_t diffuse_step(input logic signed [31:0] grad);
    longint prev [GRID_POINTS];
    longint rhs [GRID_POINTS];
    longint up [GRID_POINTS];
    longint mr [GRID_POINTS];
    longint a, g, ghost, base, den, lap;
    flux_result_t res;
    a = alpha_q;
    g = grad;
    heat_grid[GRID_POINTS-1] = '0;
    for (int i = 0; i < GRID_POINTS; i++) prev[i] = heat_grid[i];
    // explicit half, ghost flux on the left edge
    ghost = (2 * g) / GRID_POINTS;
    rhs[0] = clamp32(prev[0] + 2 * fx_mul(a, clamp32(prev[1] - prev[0] - ghost)));
    for (int i = 1; i < GRID_POINTS - 1; i++) begin
      lap = clamp32(prev[i+1] - 2 * prev[i] + prev[i-1]);
      rhs[i] = clamp32(prev[i] + fx_mul(a, lap));
    end
    rhs[GRID_POINTS-1] = prev[GRID_POINTS-1];
    // forward elimination
    base = 65536 + 2 * a;
    up[0] = clamp32(-fx_div(2 * a, base));
    mr[0] = clamp32(fx_div(rhs[0], base));
    for (int i = 0; i < GRID_POINTS - 2; i++) begin
      den = base + fx_mul(a, up[i]);
      if (den < 1) den = 1;
      up[i+1] = clamp32(-fx_div(a, den));
      mr[i+1] = clamp32(fx_div(clamp32(rhs[i+1] + fx_mul(a, mr[i])), den));
    end
    // back substitution
    heat_grid[GRID_POINTS-1] = rhs[GRID_POINTS-1];
    for (int i = GRID_POINTS - 2; i >= 0; i--) begin
      heat_grid[i] = clamp32(mr[i] - fx_mul(up[i], heat_grid[i+1]));
    end
    elapsed_q = elapsed_q + {16'd0, time_step_q};
    res.left_flux = clamp32((longint'(heat_grid[0]) - heat_grid[1]) * GRID_POINTS);
    res.right_flux = clamp32((longint'(heat_grid[GRID_POINTS-2]) -
                              heat_grid[GRID_POINTS-1]) * GRID_POINTS);
    res.elapsed_time = elapsed_q;
    return res;
  endfunction

  task automatic report_mismatch(input string what, input logic [47:0] got,
                                 input logic [47:0] want);
    $display("mismatch %s: got %h want %h at %0t", what, got, want, $realtime);
    error_count++;
  endtask

  // receiver: random stall, or a long hold-off
  always @(posedge clk) begin
    if (hold_active) begin
      m_tready <= 1'b0;
    end else begin
      m_tready <= ($urandom_range(99) >= receiver_stall_pct);
    end
  end

  always begin
    @(hold_ev);
    hold_active = 1'b1;
    repeat (HOLD_CYCLES) @(posedge clk);
    hold_active = 1'b0;
  end

  // result checker
  always @(posedge clk) begin
    flux_result_t want, got;
    if (!rst && m_tvalid && m_tready) begin
      got = flux_result_t'({m_tdata[31:0], m_tdata[63:32], m_tdata[111:64]});
      if (pending_fluxes.size() == 0) begin
        $display("unexpected result %h at %0t", m_tdata, $realtime);
        error_count++;
      end else begin
        want = pending_fluxes.pop_front();
        if (got.left_flux !== want.left_flux)
          report_mismatch("left_flux", got.left_flux, want.left_flux);
        if (got.right_flux !== want.right_flux)
          report_mismatch("right_flux", got.right_flux, want.right_flux);
        if (got.elapsed_time !== want.elapsed_time)
          report_mismatch("elapsed_time", got.elapsed_time, want.elapsed_time);
      end
    end
  end

  // watchdog on cycles with no handshake at all
  always @(posedge clk) begin
    if (rst || (s_tvalid && s_tready) || (m_tvalid && m_tready) || cfg_we) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles >= WATCHDOG_LIMIT) begin
        $display("watchdog expired at %0t", $realtime);
        $display("TEST FAILED");
        $finish;
      end
    end
  end

  task automatic write_reg(input logic idx, input logic [31:0] value);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= value;
    @(posedge clk);
    cfg_we <= 1'b0;
    if (idx == REG_ALPHA) alpha_q = value;
    else time_step_q = value;
  endtask

  // one request; valid stays high when the next one follows at once
  task automatic send_step(input logic [31:0] grad);
    s_tdata <= grad;
    s_tvalid <= 1'b1;
    do @(posedge clk); while (!s_tready);
    pending_fluxes.push_back(diffuse_step(grad));
    if ($urandom_range(99) < sender_idle_pct) begin
      s_tvalid <= 1'b0;
      repeat ($urandom_range(1, 40)) @(posedge clk);
    end
  endtask

  task automatic wait_idle();
    s_tvalid <= 1'b0;
    while (pending_fluxes.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  function automatic logic [31:0] rand_gradient();
    case ($urandom_range(3))
      0: return $urandom;
      1: return $urandom_range(3) == 0 ? 32'h8000_0000 : 32'h7FFF_FFFF;
      default: return 32'($signed($urandom_range(0, 32'h0020_0000)) - 32'sh0010_0000);
    endcase
  endfunction

  function automatic logic [31:0] rand_alpha();
    case ($urandom_range(3))
      0: return $urandom;
      1: return $urandom_range(0, 32'h0000_0100);
      default: return $urandom_range(0, 32'h0004_0000);
    endcase
  endfunction

  task automatic test_directed();
    logic [31:0] grads [10] = '{32'h0, 32'h1, 32'hFFFF_FFFF, 32'h7FFF_FFFF,
                                32'h8000_0000, 32'h0001_0000, 32'hFFFF_0000,
                                32'h0000_0040, 32'h0, 32'h0};
    write_reg(REG_ALPHA, 32'h0000_8000);
    write_reg(REG_TIME_STEP, 32'h0001_0000);
    foreach (grads[i]) send_step(grads[i]);
    wait_idle();
    // no diffusion: alpha zero, time step zero
    write_reg(REG_ALPHA, 32'h0);
    write_reg(REG_TIME_STEP, 32'h0);
    send_step(32'h7FFF_FFFF);
    send_step(32'h8000_0000);
    send_step(32'h0);
    wait_idle();
    // largest alpha and time step drive saturation and tiny pivots
    write_reg(REG_ALPHA, 32'hFFFF_FFFF);
    write_reg(REG_TIME_STEP, 32'hFFFF_FFFF);
    send_step(32'h7FFF_FFFF);
    send_step(32'h8000_0000);
    send_step(32'h7FFF_FFFF);
    send_step(32'h0);
    wait_idle();
    write_reg(REG_ALPHA, 32'h0001_0000);
    send_step(32'h8000_0000);
    send_step(32'h8000_0000);
    send_step(32'h0012_3456);
    wait_idle();
  endtask

  task automatic test_random(input int idle_s, input int stall_r, input int n);
    sender_idle_pct = idle_s;
    receiver_stall_pct = stall_r;
    write_reg(REG_ALPHA, rand_alpha());
    write_reg(REG_TIME_STEP, $urandom);
    for (int i = 0; i < n; i++) send_step(rand_gradient());
    wait_idle();
  endtask

  task automatic test_backpressure();
    sender_idle_pct = 0;
    receiver_stall_pct = 0;
    write_reg(REG_ALPHA, 32'h0000_4000);
    write_reg(REG_TIME_STEP, 32'h0000_0100);
    -> hold_ev;
    for (int i = 0; i < 6; i++) send_step(rand_gradient());
    wait_idle();
  endtask

  task automatic test_drain_pause();
    receiver_stall_pct = 30;
    for (int i = 0; i < 4; i++) send_step(rand_gradient());
    // pause until every result is back, then resume
    wait_idle();
    for (int i = 0; i < 4; i++) send_step(rand_gradient());
    wait_idle();
  endtask

  initial begin
    alpha_q = '0;
    time_step_q = '0;
    elapsed_q = '0;
    foreach (heat_grid[i]) heat_grid[i] = '0;
    repeat (6) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    test_directed();
    test_random(0, 0, 49);
    test_random(56, 0, 49);
    test_random(0, 56, 49);
    test_random(21, 21, 49);
    test_backpressure();
    test_drain_pause();
    repeat (SETTLE_CYCLES) @(posedge clk);
    if (error_count == 0 && pending_fluxes.size() == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule
